### hdl/lprb_pkg.sv
package lprb_pkg;

  localparam int DEPTH         = 4096;
  localparam int MAX_BURST     = 64;
  localparam int MAX_FRAME_DIM = 1024;
  localparam int CMDQ_DEPTH    = 2;

  localparam int PTR_W      = $clog2(DEPTH);
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int DIM_W      = $clog2(MAX_FRAME_DIM + 1);
  localparam int SIZE_W     = 2 * DIM_W;
  localparam int BURST_W    = $clog2(MAX_BURST + 1);
  localparam int NCMP_W     = (FILL_W > BURST_W) ? FILL_W : BURST_W;
  localparam int ENTRY_W    = 64;
  localparam int LOSS_W     = 32;
  localparam int FILL_OUT_W = 13;
  localparam int DIM_IN_W   = 11;
  localparam int COUNT_IN_W = 7;
  localparam int OP_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUT          = 3'd0,
    OP_FRAME_START  = 3'd1,
    OP_FRAME_SAMPLE = 3'd2,
    OP_GET          = 3'd3,
    OP_CLEAR_LOSS   = 3'd4,
    OP_READ_STATUS  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    FM_IDLE,
    FM_STORE,
    FM_DROP
  } frame_mode_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_GET_RD,
    ST_GET_OUT
  } back_state_t;

  // one decoded request as it waits between front and back
  typedef struct packed {
    op_t                op;
    logic [15:0]        depth;
    logic [15:0]        point_x;
    logic [15:0]        point_y;
    logic [15:0]        angle;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SIZE_W-1:0]  size;
    logic [BURST_W-1:0] burst;
  } cmd_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_IN_W-1:0] v);
    if (int'(v) > MAX_FRAME_DIM) return DIM_W'(MAX_FRAME_DIM);
    else return DIM_W'(v);
  endfunction

  function automatic logic [BURST_W-1:0] sat_burst(input logic [COUNT_IN_W-1:0] v);
    if (int'(v) > MAX_BURST) return BURST_W'(MAX_BURST);
    else return BURST_W'(v);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] q;
    q = {1'b0, p} + 1'b1;
    if (int'(q) >= DEPTH) return '0;
    else return q[PTR_W-1:0];
  endfunction

  function automatic logic [LOSS_W-1:0] sat_add(input logic [LOSS_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [LOSS_W:0] s;
    s = {1'b0, a} + (LOSS_W+1)'(b);
    if (s[LOSS_W]) return '1;
    else return s[LOSS_W-1:0];
  endfunction

endpackage

### hdl/lossy_point_ring_buffer.sv
// channel   direction  handshake              contents
// in_*      input      in_valid / in_ready    one request: operation and its fields
// out_*     output     out_valid / out_ready  one result: popped entry and status
// cfg_*     input      cfg_we, no wait        overwrite enable
//
// a request is taken in the back end once the result register is free; a
// get of n entries then does one store read and one result per entry, as
// set by the single registered read port.
// a two-deep request queue holds up to two requests while a get runs.
// rst_n is synchronous; the entry store itself is not cleared.
module lossy_point_ring_buffer import lprb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_operation,
  input  logic signed [15:0]     in_depth,
  input  logic signed [15:0]     in_point_x,
  input  logic signed [15:0]     in_point_y,
  input  logic [DIM_IN_W-1:0]    in_frame_width,
  input  logic [DIM_IN_W-1:0]    in_frame_height,
  input  logic signed [15:0]     in_angle,
  input  logic [COUNT_IN_W-1:0]  in_get_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_entry_valid,
  output logic signed [15:0]     out_depth,
  output logic signed [15:0]     out_x,
  output logic signed [15:0]     out_y,
  output logic signed [15:0]     out_angle,
  output logic                   out_last,
  output logic                   out_accepted,
  output logic                   out_overflow_flag,
  output logic                   out_last_put_overflow,
  output logic [LOSS_W-1:0]      out_loss_count,
  output logic [FILL_OUT_W-1:0]  out_fill_level
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  lprb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_depth        (in_depth),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_frame_width  (in_frame_width),
    .in_frame_height (in_frame_height),
    .in_angle        (in_angle),
    .in_get_count    (in_get_count),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  lprb_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .cmd_valid             (cmd_valid),
    .cmd                   (cmd),
    .cmd_pop               (cmd_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_entry_valid       (out_entry_valid),
    .out_depth             (out_depth),
    .out_x                 (out_x),
    .out_y                 (out_y),
    .out_angle             (out_angle),
    .out_last              (out_last),
    .out_accepted          (out_accepted),
    .out_overflow_flag     (out_overflow_flag),
    .out_last_put_overflow (out_last_put_overflow),
    .out_loss_count        (out_loss_count),
    .out_fill_level        (out_fill_level)
  );

endmodule

### hdl/lprb_ram.sv
module lprb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/lprb_front.sv
module lprb_front import lprb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_operation,
  input  logic signed [15:0]    in_depth,
  input  logic signed [15:0]    in_point_x,
  input  logic signed [15:0]    in_point_y,
  input  logic [DIM_IN_W-1:0]   in_frame_width,
  input  logic [DIM_IN_W-1:0]   in_frame_height,
  input  logic signed [15:0]    in_angle,
  input  logic [COUNT_IN_W-1:0] in_get_count,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  localparam int QI_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             q_r [CMDQ_DEPTH];
  logic [QI_W-1:0]  head_r, head_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;
  logic [QI_W-1:0]  tail;
  logic             push;
  cmd_t             dec;
  logic [DIM_W-1:0] w_sat, h_sat;

  function automatic logic [QI_W-1:0] qi_inc(input logic [QI_W-1:0] i);
    if (int'(i) >= CMDQ_DEPTH - 1) return '0;
    else return QI_W'(i + 1'b1);
  endfunction

  // classify and saturate on the way in; frame size is formed here
  always_comb begin
    w_sat      = sat_dim(in_frame_width);
    h_sat      = sat_dim(in_frame_height);
    dec.op     = op_t'(in_operation);
    dec.depth  = in_depth;
    dec.point_x = in_point_x;
    dec.point_y = in_point_y;
    dec.angle  = in_angle;
    dec.width  = w_sat;
    dec.height = h_sat;
    dec.size   = SIZE_W'(w_sat) * SIZE_W'(h_sat);
    dec.burst  = sat_burst(in_get_count);
  end

  assign in_ready  = (int'(count_r) < CMDQ_DEPTH);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[head_r];

  always_comb begin
    tail = head_r;
    for (int i = 0; i < CMDQ_DEPTH; i++) begin
      if (i < int'(count_r)) tail = qi_inc(tail);
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd_pop) begin
      head_nxt = qi_inc(head_r);
    end
    case ({push, cmd_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail] <= dec;
    end
  end

endmodule

### hdl/lprb_back.sv
module lprb_back import lprb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_entry_valid,
  output logic signed [15:0]     out_depth,
  output logic signed [15:0]     out_x,
  output logic signed [15:0]     out_y,
  output logic signed [15:0]     out_angle,
  output logic                   out_last,
  output logic                   out_accepted,
  output logic                   out_overflow_flag,
  output logic                   out_last_put_overflow,
  output logic [LOSS_W-1:0]      out_loss_count,
  output logic [FILL_OUT_W-1:0]  out_fill_level
);

  back_state_t       state_r, state_nxt;
  logic              ow_r;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic              drop_r, drop_nxt;
  logic [LOSS_W-1:0] loss_r, loss_nxt;
  frame_mode_t       mode_r, mode_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  cols_r, cols_nxt;
  logic [DIM_W-1:0]  rows_r, rows_nxt;
  logic [15:0]       tag_r, tag_nxt;
  logic [BURST_W-1:0] remain_r, remain_nxt;

  logic               slot_free;
  logic [BURST_W-1:0] get_n;
  logic [FILL_W-1:0]  free_space;
  logic               store_full;

  logic               push_req;
  logic [ENTRY_W-1:0] push_data;
  logic               ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               emit, emit_valid, emit_last, emit_acc, emit_old_drop;
  logic [ENTRY_W-1:0] emit_entry;

  logic               out_valid_r;
  logic               out_entry_valid_r, out_last_r, out_acc_r, out_ovf_r, out_drop_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic [LOSS_W-1:0]  out_loss_r;
  logic [FILL_OUT_W-1:0] out_fill_r;

  lprb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (push_data),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign slot_free  = !out_valid_r || out_ready;
  assign store_full = (int'(fill_r) >= DEPTH);
  assign free_space = FILL_W'(DEPTH) - fill_r;
  assign get_n      = (NCMP_W'(cmd.burst) > NCMP_W'(fill_r)) ? BURST_W'(fill_r) : cmd.burst;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EXEC: begin
        if (cmd_valid && slot_free && cmd.op == OP_GET && get_n != '0) begin
          state_nxt = ST_GET_RD;
        end
      end
      ST_GET_RD: state_nxt = ST_GET_OUT;
      ST_GET_OUT: begin
        if (slot_free) begin
          state_nxt = (remain_r == BURST_W'(1)) ? ST_EXEC : ST_GET_RD;
        end
      end
      default: state_nxt = ST_EXEC;
    endcase
  end

  // request execution
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    drop_nxt   = drop_r;
    loss_nxt   = loss_r;
    mode_nxt   = mode_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    tag_nxt    = tag_r;
    remain_nxt = remain_r;
    cmd_pop    = 1'b0;
    push_req   = 1'b0;
    push_data  = '0;
    ram_re     = 1'b0;
    emit       = 1'b0;
    emit_valid = 1'b0;
    emit_last  = 1'b1;
    emit_acc   = 1'b0;
    emit_old_drop = 1'b0;
    emit_entry = '0;

    unique case (state_r)
      ST_EXEC: begin
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          emit    = 1'b1;
          unique case (cmd.op)
            OP_PUT: begin
              if (ovf_r && !ow_r) begin
                loss_nxt = sat_add(loss_r, SIZE_W'(1));
                if (!store_full) ovf_nxt = 1'b0;
              end else if (store_full && !ow_r) begin
                loss_nxt = sat_add(loss_r, SIZE_W'(1));
                ovf_nxt  = 1'b1;
              end else begin
                push_req  = 1'b1;
                push_data = {16'h0000, cmd.point_y, cmd.point_x, cmd.depth};
                if (int'(fill_r) >= DEPTH - 1) ovf_nxt = 1'b1;
                emit_acc  = 1'b1;
              end
            end
            OP_FRAME_START: begin
              cols_nxt = cmd.width;
              rows_nxt = cmd.height;
              col_nxt  = '0;
              row_nxt  = '0;
              tag_nxt  = cmd.angle;
              if ((LOSS_W+1)'(cmd.size) > (LOSS_W+1)'(free_space) && !ow_r) begin
                loss_nxt = sat_add(loss_r, cmd.size);
                drop_nxt = 1'b1;
                mode_nxt = (cmd.size != '0) ? FM_DROP : FM_IDLE;
              end else begin
                mode_nxt = (cmd.size != '0) ? FM_STORE : FM_IDLE;
                emit_acc = 1'b1;
              end
            end
            OP_FRAME_SAMPLE: begin
              if (mode_r != FM_IDLE) begin
                if (mode_r == FM_STORE) begin
                  if (store_full && !ow_r) begin
                    loss_nxt = sat_add(loss_r, SIZE_W'(1));
                  end else begin
                    push_req  = 1'b1;
                    push_data = {tag_r, 16'(row_r), 16'(col_r), cmd.depth};
                    emit_acc  = 1'b1;
                  end
                end
                // step the generated coordinates
                if ({1'b0, col_r} + 1'b1 >= {1'b0, cols_r}) begin
                  col_nxt = '0;
                  row_nxt = DIM_W'(row_r + 1'b1);
                  if ({1'b0, row_r} + 1'b1 >= {1'b0, rows_r}) mode_nxt = FM_IDLE;
                end else begin
                  col_nxt = DIM_W'(col_r + 1'b1);
                end
              end
            end
            OP_GET: begin
              if (get_n == '0) begin
                emit = 1'b1;
              end else begin
                emit       = 1'b0;
                remain_nxt = get_n;
              end
            end
            OP_CLEAR_LOSS: begin
              loss_nxt = '0;
            end
            OP_READ_STATUS: begin
              emit_old_drop = 1'b1;
              drop_nxt      = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_GET_RD: begin
        ram_re = 1'b1;
      end
      ST_GET_OUT: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_valid = 1'b1;
          emit_entry = ram_rdata;
          emit_last  = (remain_r == BURST_W'(1));
          emit_acc   = 1'b1;
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          fill_nxt   = fill_r - 1'b1;
          remain_nxt = remain_r - 1'b1;
        end
      end
      default: begin
      end
    endcase

    // store one entry; a full store in overwrite mode loses its oldest
    if (push_req) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      if (store_full) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        loss_nxt   = sat_add(loss_r, SIZE_W'(1));
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  assign ram_we = push_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      ow_r        <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      drop_r      <= 1'b0;
      loss_r      <= '0;
      mode_r      <= FM_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      cols_r      <= '0;
      rows_r      <= '0;
      tag_r       <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) ow_r <= cfg_wdata;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      ovf_r    <= ovf_nxt;
      drop_r   <= drop_nxt;
      loss_r   <= loss_nxt;
      mode_r   <= mode_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      cols_r   <= cols_nxt;
      rows_r   <= rows_nxt;
      tag_r    <= tag_nxt;
      remain_r <= remain_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result register, status as left by the request (a status read shows the old drop flag)
  always_ff @(posedge clk) begin
    if (emit) begin
      out_entry_valid_r <= emit_valid;
      out_entry_r       <= emit_entry;
      out_last_r        <= emit_last;
      out_acc_r         <= emit_acc;
      out_ovf_r         <= ovf_nxt;
      out_drop_r        <= emit_old_drop ? drop_r : drop_nxt;
      out_loss_r        <= loss_nxt;
      out_fill_r        <= FILL_OUT_W'(fill_nxt);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_entry_valid       = out_entry_valid_r;
  assign out_depth             = out_entry_r[15:0];
  assign out_x                 = out_entry_r[31:16];
  assign out_y                 = out_entry_r[47:32];
  assign out_angle             = out_entry_r[63:48];
  assign out_last              = out_last_r;
  assign out_accepted          = out_acc_r;
  assign out_overflow_flag     = out_ovf_r;
  assign out_last_put_overflow = out_drop_r;
  assign out_loss_count        = out_loss_r;
  assign out_fill_level        = out_fill_r;

endmodule
